// File: src/rfft_pkg.sv
package rfft_pkg;

    localparam int POINTS_DEF = 64;
    localparam int SAMPLE_W   = 16;
    localparam int DATA_W     = 24;
    localparam int BIN_IDX_W  = 6;
    localparam int TW_W       = 17;
    localparam int TW_MW      = 5;
    localparam int PROD_W     = DATA_W + TW_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int Q_SHIFT    = 15;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DATA_W-1:0]   t_data;
    typedef logic [2*DATA_W-1:0]        t_word;
    typedef logic [BIN_IDX_W-1:0]       t_bin_idx;
    typedef logic signed [TW_W-1:0]     t_tw;
    typedef logic [TW_MW-1:0]           t_tw_idx;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_SUM,
        ST_BF_WA,
        ST_BF_WB,
        ST_OUT_RD,
        ST_OUT_VLD
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_load;
    } t_mem_ctrl;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic sub;
    } t_bf_ctrl;

    // round(32768 * cos(2*pi*m/64)) for the first quarter turn
    localparam t_tw QCOS [0:16] = '{
        17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
        17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
        17'sd12540, 17'sd9512,  17'sd6393,  17'sd3212,  17'sd0
    };

    localparam t_tw_idx TW_QUARTER = t_tw_idx'(16);

    function automatic t_tw tw_cos(input t_tw_idx m);
        t_tw v;
        if (m <= TW_QUARTER) begin
            v = QCOS[m];
        end else begin
            v = -QCOS[t_tw_idx'(0) - m];
        end
        return v;
    endfunction

    function automatic t_tw tw_sin(input t_tw_idx m);
        t_tw v;
        if (m <= TW_QUARTER) begin
            v = QCOS[TW_QUARTER - m];
        end else begin
            v = QCOS[m - TW_QUARTER];
        end
        return v;
    endfunction

endpackage

// File: src/rfft_if.sv
interface rfft_in_if;
    logic             valid;
    logic             ready;
    rfft_pkg::t_sample sample_re;
    rfft_pkg::t_sample sample_im;

    modport source (output valid, output sample_re, output sample_im, input ready);
    modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface rfft_out_if;
    logic               valid;
    logic               ready;
    rfft_pkg::t_data    bin_re;
    rfft_pkg::t_data    bin_im;
    rfft_pkg::t_bin_idx bin_index;
    logic               last_bin;

    modport source (output valid, output bin_re, output bin_im, output bin_index,
                    output last_bin, input ready);
    modport sink   (input valid, input bin_re, input bin_im, input bin_index,
                    input last_bin, output ready);
endinterface

// File: src/rfft_bfly.sv
module rfft_bfly (
    input  logic               i_clk,
    input  rfft_pkg::t_bf_ctrl i_ctrl,
    input  rfft_pkg::t_word    i_even,
    input  rfft_pkg::t_word    i_odd,
    input  rfft_pkg::t_tw      i_tw_cos,
    input  rfft_pkg::t_tw      i_tw_sin,
    output rfft_pkg::t_word    o_wr_data
);

    localparam rfft_pkg::t_acc HALF_LSB = rfft_pkg::t_acc'(1) <<< (rfft_pkg::Q_SHIFT - 1);

    rfft_pkg::t_data odd_re, odd_im, even_re, even_im;
    rfft_pkg::t_prod r_p_rc, r_p_is, r_p_ic, r_p_rs;
    rfft_pkg::t_acc  sum_re, sum_im;
    rfft_pkg::t_data r_t_re, r_t_im;
    rfft_pkg::t_data res_re, res_im;

    assign odd_re  = i_odd[2*rfft_pkg::DATA_W-1:rfft_pkg::DATA_W];
    assign odd_im  = i_odd[rfft_pkg::DATA_W-1:0];
    assign even_re = i_even[2*rfft_pkg::DATA_W-1:rfft_pkg::DATA_W];
    assign even_im = i_even[rfft_pkg::DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_p_rc <= rfft_pkg::t_prod'(odd_re) * rfft_pkg::t_prod'(i_tw_cos);
            r_p_is <= rfft_pkg::t_prod'(odd_im) * rfft_pkg::t_prod'(i_tw_sin);
            r_p_ic <= rfft_pkg::t_prod'(odd_im) * rfft_pkg::t_prod'(i_tw_cos);
            r_p_rs <= rfft_pkg::t_prod'(odd_re) * rfft_pkg::t_prod'(i_tw_sin);
        end
    end

    // round half up, then drop the Q15 fraction
    assign sum_re = rfft_pkg::t_acc'(r_p_rc) + rfft_pkg::t_acc'(r_p_is) + HALF_LSB;
    assign sum_im = rfft_pkg::t_acc'(r_p_ic) - rfft_pkg::t_acc'(r_p_rs) + HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_en) begin
            r_t_re <= sum_re[rfft_pkg::Q_SHIFT+rfft_pkg::DATA_W-1:rfft_pkg::Q_SHIFT];
            r_t_im <= sum_im[rfft_pkg::Q_SHIFT+rfft_pkg::DATA_W-1:rfft_pkg::Q_SHIFT];
        end
    end

    always_comb begin
        if (i_ctrl.sub) begin
            res_re = even_re - r_t_re;
            res_im = even_im - r_t_im;
        end else begin
            res_re = even_re + r_t_re;
            res_im = even_im + r_t_im;
        end
    end

    assign o_wr_data = {res_re, res_im};

endmodule

// File: src/rfft_seq.sv
module rfft_seq #(
    parameter int POINTS = rfft_pkg::POINTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rfft_pkg::t_mem_ctrl         o_mem,
    output rfft_pkg::t_bf_ctrl          o_bf,
    output logic [$clog2(POINTS)-1:0]   o_rd_addr_a,
    output logic [$clog2(POINTS)-1:0]   o_rd_addr_b,
    output logic [$clog2(POINTS)-1:0]   o_wr_addr,
    output logic [$clog2(POINTS)-1:0]   o_bin_index,
    output logic                        o_last_bin,
    output rfft_pkg::t_tw               o_tw_cos,
    output rfft_pkg::t_tw               o_tw_sin
);

    localparam int AW = $clog2(POINTS);
    localparam int LG = AW;
    localparam int SW = (LG > 1) ? $clog2(LG) : 1;

    typedef logic [AW-1:0] t_addr;
    typedef logic [SW-1:0] t_stage;

    localparam t_addr  LAST_BF    = t_addr'(POINTS / 2 - 1);
    localparam t_stage LAST_STAGE = t_stage'(LG - 1);

    rfft_pkg::t_state r_state, n_state;
    t_addr            r_cnt;
    t_stage           r_stage;
    rfft_pkg::t_tw    r_tw_cos, r_tw_sin;

    t_addr             load_addr, mask, lo, addr_a, addr_b;
    logic [2:0]        tw_sh;
    rfft_pkg::t_tw_idx tw_m;
    logic              in_beat, out_beat;

    assign in_beat  = (r_state == rfft_pkg::ST_LOAD) && i_in_valid;
    assign out_beat = (r_state == rfft_pkg::ST_OUT_VLD) && i_out_ready;

    // sample n lands at its bit-reversed slot, so no reorder pass is needed
    always_comb begin
        for (int i = 0; i < AW; i++) begin
            load_addr[i] = r_cnt[AW-1-i];
        end
    end

    // butterfly j of a stage: insert a zero at the stage bit for the even leg
    always_comb begin
        mask   = (t_addr'(1) << r_stage) - t_addr'(1);
        lo     = r_cnt & mask;
        addr_a = ((r_cnt & ~mask) << 1) | lo;
        addr_b = addr_a | (t_addr'(1) << r_stage);
        tw_sh  = 3'(rfft_pkg::TW_MW) - 3'(r_stage);
        tw_m   = rfft_pkg::t_tw_idx'(lo) << tw_sh;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rfft_pkg::ST_LOAD: begin
                if (in_beat && (&r_cnt)) n_state = rfft_pkg::ST_BF_RD;
            end
            rfft_pkg::ST_BF_RD:  n_state = rfft_pkg::ST_BF_MUL;
            rfft_pkg::ST_BF_MUL: n_state = rfft_pkg::ST_BF_SUM;
            rfft_pkg::ST_BF_SUM: n_state = rfft_pkg::ST_BF_WA;
            rfft_pkg::ST_BF_WA:  n_state = rfft_pkg::ST_BF_WB;
            rfft_pkg::ST_BF_WB: begin
                if (r_cnt == LAST_BF && r_stage == LAST_STAGE) begin
                    n_state = rfft_pkg::ST_OUT_RD;
                end else begin
                    n_state = rfft_pkg::ST_BF_RD;
                end
            end
            rfft_pkg::ST_OUT_RD: n_state = rfft_pkg::ST_OUT_VLD;
            rfft_pkg::ST_OUT_VLD: begin
                if (out_beat) begin
                    n_state = (&r_cnt) ? rfft_pkg::ST_LOAD : rfft_pkg::ST_OUT_RD;
                end
            end
            default: n_state = rfft_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        o_mem          = '0;
        o_bf           = '0;
        o_rd_addr_a    = addr_a;
        o_wr_addr      = addr_a;
        case (r_state)
            rfft_pkg::ST_LOAD: begin
                o_in_ready    = 1'b1;
                o_mem.wr_en   = i_in_valid;
                o_mem.wr_load = 1'b1;
                o_wr_addr     = load_addr;
            end
            rfft_pkg::ST_BF_RD:  o_mem.rd_en = 1'b1;
            rfft_pkg::ST_BF_MUL: o_bf.mul_en = 1'b1;
            rfft_pkg::ST_BF_SUM: o_bf.sum_en = 1'b1;
            rfft_pkg::ST_BF_WA:  o_mem.wr_en = 1'b1;
            rfft_pkg::ST_BF_WB: begin
                o_mem.wr_en = 1'b1;
                o_bf.sub    = 1'b1;
                o_wr_addr   = addr_b;
            end
            rfft_pkg::ST_OUT_RD: begin
                o_mem.rd_en = 1'b1;
                o_rd_addr_a = r_cnt;
            end
            rfft_pkg::ST_OUT_VLD: o_out_valid = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign o_rd_addr_b = addr_b;
    assign o_bin_index = r_cnt;
    assign o_last_bin  = &r_cnt;
    assign o_tw_cos    = r_tw_cos;
    assign o_tw_sin    = r_tw_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfft_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            if (in_beat || out_beat) begin
                r_cnt <= r_cnt + t_addr'(1);
            end
            if (in_beat && (&r_cnt)) begin
                r_stage <= '0;
            end
            if (r_state == rfft_pkg::ST_BF_WB) begin
                if (r_cnt == LAST_BF) begin
                    r_cnt <= '0;
                    if (r_stage != LAST_STAGE) r_stage <= r_stage + t_stage'(1);
                end else begin
                    r_cnt <= r_cnt + t_addr'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rfft_pkg::ST_BF_RD) begin
            r_tw_cos <= rfft_pkg::tw_cos(tw_m);
            r_tw_sin <= rfft_pkg::tw_sin(tw_m);
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open at once");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (&r_cnt)) |=>
        (r_state == rfft_pkg::ST_BF_RD && r_cnt == '0 && r_stage == '0))
        else $error("transform did not start at first butterfly");

    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage <= LAST_STAGE)
        else $error("stage counter out of range");

    a_legs_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfft_pkg::ST_BF_WA) |=>
        (o_wr_addr == ($past(o_wr_addr) | (t_addr'(1) << r_stage))
         && o_wr_addr != $past(o_wr_addr)))
        else $error("odd leg address does not pair with even leg");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && (&r_cnt)) |=> (r_state == rfft_pkg::ST_LOAD && r_cnt == '0))
        else $error("frame did not return to loading after last bin");

endmodule

// File: src/radix2_fft_frame.sv
// Frame FFT, radix-2 decimation in time, forward transform.
// i_sample: one beat per complex Q1.15 time sample. After POINTS beats the
// input closes (ready low) while the transform runs in place in the sample
// store and the bins are read out.
// o_bin: POINTS beats per frame, bins 0..POINTS-1 in natural order, 24-bit
// signed with full growth; last_bin marks bin POINTS-1. When the last bin
// is taken the input opens again for the next frame.
// Schedule: loading takes POINTS beats. The transform runs
// (POINTS/2)*log2(POINTS) butterflies on one shared complex multiply unit;
// each one reads both legs, multiplies, rounds, writes the even leg, then
// writes the odd leg. Each bin is a store read, then the beat, so the
// first bin is valid after the store read that follows the transform.
// Stall: a bin holds on o_bin until taken; nothing else advances meanwhile.
// Reset (i_rst_n low, synchronous): drops any partial frame and opens the
// input for sample 0; the store needs no clearing.
module radix2_fft_frame #(
    parameter int POINTS = rfft_pkg::POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfft_in_if.sink     i_sample,
    rfft_out_if.source  o_bin
);

    localparam int AW = $clog2(POINTS);

    rfft_pkg::t_word r_store [0:POINTS-1];
    rfft_pkg::t_word r_rd_a, r_rd_b;
    rfft_pkg::t_word wr_data, bf_data;

    rfft_pkg::t_mem_ctrl mem;
    rfft_pkg::t_bf_ctrl  bf;
    logic [AW-1:0]       rd_addr_a, rd_addr_b, wr_addr, bin_index;
    logic                last_bin;
    rfft_pkg::t_tw       tw_cos, tw_sin;

    rfft_seq #(
        .POINTS (POINTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_bin.valid),
        .i_out_ready (o_bin.ready),
        .o_mem       (mem),
        .o_bf        (bf),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_wr_addr   (wr_addr),
        .o_bin_index (bin_index),
        .o_last_bin  (last_bin),
        .o_tw_cos    (tw_cos),
        .o_tw_sin    (tw_sin)
    );

    rfft_bfly u_bfly (
        .i_clk     (i_clk),
        .i_ctrl    (bf),
        .i_even    (r_rd_a),
        .i_odd     (r_rd_b),
        .i_tw_cos  (tw_cos),
        .i_tw_sin  (tw_sin),
        .o_wr_data (bf_data)
    );

    assign wr_data = mem.wr_load
        ? {rfft_pkg::t_data'(i_sample.sample_re), rfft_pkg::t_data'(i_sample.sample_im)}
        : bf_data;

    always_ff @(posedge i_clk) begin
        if (mem.wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        if (mem.rd_en) begin
            r_rd_a <= r_store[rd_addr_a];
            r_rd_b <= r_store[rd_addr_b];
        end
    end

    // read register doubles as the output register while a bin waits
    assign o_bin.bin_re    = r_rd_a[2*rfft_pkg::DATA_W-1:rfft_pkg::DATA_W];
    assign o_bin.bin_im    = r_rd_a[rfft_pkg::DATA_W-1:0];
    assign o_bin.bin_index = rfft_pkg::t_bin_idx'(bin_index);
    assign o_bin.last_bin  = last_bin;

endmodule
